### hw/rtl/mnbm_pkg.sv
// Shared types, codes and fixed-point constants for the tanh neuron trainer.
// Also holds the elaboration-time exp series used to build the tanh table. No dependencies.
package mnbm_pkg;

  // Fixed-point format and table geometry
  localparam int FRAC_BITS        = 12;
  localparam int TANH_TABLE_DEPTH = 1024;
  localparam int TANH_AW          = $clog2(TANH_TABLE_DEPTH);
  localparam int ACC_W            = 40;
  localparam int ACC_HALF         = ACC_W / 2;

  // Table index is a slice of (acc + 4.0) in Q.2F
  localparam int TIDX_HI = 2 + 2 * FRAC_BITS;
  localparam int TIDX_LO = 3 + 2 * FRAC_BITS - TANH_AW;

  localparam logic signed [ACC_W-1:0] ACC_LIM  = ACC_W'(4) << (2 * FRAC_BITS);
  localparam logic signed [ACC_W-1:0] ACC_NLIM = -ACC_LIM;
  localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [15:0]      ONE_Q    = 16'(1 << FRAC_BITS);
  localparam logic [63:0]             ONE_Q30  = 64'd1 << 30;

  // Item modes
  localparam logic [2:0] MODE_LOAD     = 3'd0;
  localparam logic [2:0] MODE_FORWARD  = 3'd1;
  localparam logic [2:0] MODE_OUT_GRAD = 3'd2;
  localparam logic [2:0] MODE_HID_GRAD = 3'd3;
  localparam logic [2:0] MODE_UPDATE   = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_ACT    = 2'd0;
  localparam logic [1:0] KIND_GRAD   = 2'd1;
  localparam logic [1:0] KIND_WEIGHT = 2'd2;

  // Register indexes
  localparam logic [0:0] REG_LEARNING_RATE = 1'd0;
  localparam logic [0:0] REG_MOMENTUM      = 1'd1;

  typedef struct packed {
    logic [2:0]          mode;
    logic [5:0]          input_index;
    logic signed [15:0]  operand_value;
    logic signed [15:0]  partner_weight;
    logic                last_term;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]  result_value;
    logic [1:0]          result_kind;
    logic                saturated;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_FMUL, ST_HMUL, ST_ACC, ST_TIDX, ST_TOUT,
    ST_SQ, ST_DER, ST_GMUL, ST_GOUT, ST_HLO, ST_HHI, ST_HSUM, ST_HOUT,
    ST_UMUL1, ST_UMUL2, ST_UMUL3, ST_USUM, ST_UOUT
  } state_t;

  typedef enum logic [1:0] {
    TC_MID, TC_NEG, TC_POS
  } tclass_t;

  // Clip a 32-bit value to 16 bits; top bit of the result is the clip flag
  function automatic logic [16:0] sat16(input logic signed [31:0] v);
    logic [16:0] r;
    if (v > 32'sd32767) begin
      r = {1'b1, 16'h7fff};
    end else if (v < -32'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

  // exp(-2|x|) in Q0.30 for x = -4 + 8i/DEPTH: Taylor series of exp(-|x|/8),
  // then squared four times
  function automatic logic [63:0] tanh_exp(input int unsigned i);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] num;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    a = 64'(8 * i);
    b = 64'(4 * TANH_TABLE_DEPTH);
    num = (a < b) ? b - a : a - b;
    z = (num << 30) >> (3 + TANH_AW);
    term = ONE_Q30;
    sum = ONE_Q30;
    term = (term * z) >> 30;
    sum = sum - term;
    term = ((term * z) >> 30) / 64'd2;
    sum = sum + term;
    term = ((term * z) >> 30) / 64'd3;
    sum = sum - term;
    term = ((term * z) >> 30) / 64'd4;
    sum = sum + term;
    term = ((term * z) >> 30) / 64'd5;
    sum = sum - term;
    term = ((term * z) >> 30) / 64'd6;
    sum = sum + term;
    term = ((term * z) >> 30) / 64'd7;
    sum = sum - term;
    term = ((term * z) >> 30) / 64'd8;
    sum = sum + term;
    term = ((term * z) >> 30) / 64'd9;
    sum = sum - term;
    term = ((term * z) >> 30) / 64'd10;
    sum = sum + term;
    term = ((term * z) >> 30) / 64'd11;
    sum = sum - term;
    term = ((term * z) >> 30) / 64'd12;
    sum = sum + term;
    e = sum;
    for (int r = 0; r < 4; r++) begin
      e = (e * e) >> 30;
    end
    return e;
  endfunction

endpackage

### hw/rtl/mnbm_tanh_rom.sv
// Registered-read tanh lookup ROM over [-4, 4).
// Depends on mnbm_pkg for the table geometry and exp series.
module mnbm_tanh_rom (
  input  logic                              clk,
  input  logic [mnbm_pkg::TANH_AW-1:0]      addr,
  output logic signed [15:0]                data
);

  logic [15:0] tanh_rom [mnbm_pkg::TANH_TABLE_DEPTH];

  // Build each entry as an elaboration constant: round((1 - e) / (1 + e))
  for (genvar i = 0; i < mnbm_pkg::TANH_TABLE_DEPTH; i++) begin : g_entry
    localparam logic [63:0] E     = mnbm_pkg::tanh_exp(i);
    localparam logic [63:0] DEN   = mnbm_pkg::ONE_Q30 + E;
    localparam logic [63:0] MAG   =
      (((mnbm_pkg::ONE_Q30 - E) << mnbm_pkg::FRAC_BITS) + (DEN >> 1)) / DEN;
    localparam logic [15:0] ENTRY =
      (i < (mnbm_pkg::TANH_TABLE_DEPTH >> 1)) ? 16'(-MAG) : 16'(MAG);
    assign tanh_rom[i] = ENTRY;
  end

  // Register the read
  always_ff @(posedge clk) begin
    data <= tanh_rom[addr];
  end

endmodule

### hw/rtl/mlp_neuron_backprop_momentum.sv
// Top level of the tanh neuron trainer: sequencer, shared multiplier, stores.
// Depends on mnbm_pkg and mnbm_tanh_rom.
//
// One item is handled at a time; in_stall is high until the sequencer is back
// in idle, so a new item is taken only after the last one is through. The
// steps are set by the single 30 x 17 bit multiplier with a registered
// product that the forward, gradient and update modes share; a final step
// holds while the output register is still full. Weights and deltas live in
// two single-write memories read at the input transfer; deltas carry
// per-entry valid bits so they read as zero after reset. No clearing pass
// is needed. Configuration writes apply at once.
module mlp_neuron_backprop_momentum #(
  parameter int MAX_INPUTS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mnbm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mnbm_pkg::out_item_t  out_data,
  input  logic                 cfg_write,
  input  logic [0:0]           cfg_index,
  input  logic [11:0]          cfg_data
);

  localparam int AW = $clog2(MAX_INPUTS);
  localparam int XW = AW + 6;
  localparam int F  = mnbm_pkg::FRAC_BITS;
  localparam int HW = 47 + mnbm_pkg::ACC_HALF + 1;

  mnbm_pkg::state_t  state;
  mnbm_pkg::state_t  state_next;
  mnbm_pkg::in_item_t cur;
  mnbm_pkg::tclass_t tcls;

  logic                        cur_ok;
  logic signed [15:0]          w_rd;
  logic signed [15:0]          d_rd;
  logic                        dv_rd;
  logic signed [mnbm_pkg::ACC_W-1:0] acc;
  logic signed [15:0]          nout;
  logic signed [15:0]          ngrad;
  logic [11:0]                 eta;
  logic [11:0]                 alpha;
  logic signed [46:0]          prod;
  logic signed [13:0]          dreg;
  logic [46:0]                 plo;
  logic signed [31:0]          gsum;
  logic signed [46:0]          areg;
  logic signed [31:0]          nd;

  logic signed [15:0] weight_mem [MAX_INPUTS];
  logic signed [15:0] delta_mem  [MAX_INPUTS];
  logic [MAX_INPUTS-1:0] dvalid;

  logic in_xfer;
  logic out_free;
  logic emit;
  mnbm_pkg::out_item_t emit_data;
  logic signed [29:0] mul_a;
  logic signed [16:0] mul_b;

  logic [XW-1:0] in_idx_x;
  logic [XW-1:0] cur_idx_x;
  logic [AW-1:0] in_addr;
  logic [AW-1:0] cur_addr;
  logic          in_ok;

  logic signed [mnbm_pkg::ACC_W:0]   acc_sum;
  logic signed [mnbm_pkg::ACC_W-1:0] acc_next;
  logic [mnbm_pkg::ACC_W-1:0]        acc_off;
  logic [mnbm_pkg::TANH_AW-1:0]      rom_addr;
  logic signed [15:0]                rom_data;
  logic signed [15:0]                tout_val;
  logic signed [13:0]                dreg_next;
  logic signed [16:0]                gdiff;
  logic [16:0]                       g_sat;
  logic signed [HW-1:0]              h_total;
  logic [16:0]                       h_sat;
  logic signed [63:0]                u_sum;
  logic signed [15:0]                old_delta;
  logic [16:0]                       dsat;
  logic signed [31:0]                wsum;
  logic [16:0]                       wsat;

  // Address decode for the port index and the captured index
  assign in_idx_x  = XW'(in_data.input_index);
  assign cur_idx_x = XW'(cur.input_index);
  assign in_addr   = in_idx_x[AW-1:0];
  assign cur_addr  = cur_idx_x[AW-1:0];
  assign in_ok     = in_idx_x < XW'(MAX_INPUTS);

  assign in_stall = (state != mnbm_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Accumulate with clamping at the 40 bit limits
  assign acc_sum  = {acc[mnbm_pkg::ACC_W-1], acc} + prod[mnbm_pkg::ACC_W:0];
  assign acc_next = (acc_sum[mnbm_pkg::ACC_W] != acc_sum[mnbm_pkg::ACC_W-1]) ?
                    (acc_sum[mnbm_pkg::ACC_W] ? mnbm_pkg::ACC_MIN : mnbm_pkg::ACC_MAX) :
                    acc_sum[mnbm_pkg::ACC_W-1:0];

  // Tanh lookup off the accumulator
  assign acc_off  = acc + mnbm_pkg::ACC_LIM;
  assign rom_addr = acc_off[mnbm_pkg::TIDX_HI:mnbm_pkg::TIDX_LO];

  mnbm_tanh_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  always_comb begin
    case (tcls)
      mnbm_pkg::TC_NEG: tout_val = -mnbm_pkg::ONE_Q;
      mnbm_pkg::TC_POS: tout_val = mnbm_pkg::ONE_Q;
      default:          tout_val = rom_data;
    endcase
  end

  // Derivative 1 - out*out from the squared output
  assign dreg_next = 14'(mnbm_pkg::ONE_Q) - 14'(prod[F +: 14]);
  assign gdiff     = {cur.operand_value[15], cur.operand_value} - {nout[15], nout};
  assign g_sat     = mnbm_pkg::sat16(prod[F +: 32]);

  // Recombine the split accumulator product
  assign h_total = (HW'(prod) <<< mnbm_pkg::ACC_HALF) + $signed(HW'(plo));
  assign h_sat   = mnbm_pkg::sat16(gsum);

  // Momentum rule
  assign u_sum     = 64'(areg) + (64'(prod) <<< F);
  assign old_delta = dv_rd ? d_rd : 16'sd0;
  assign dsat      = mnbm_pkg::sat16(nd);
  assign wsum      = 32'(w_rd) + 32'($signed(dsat[15:0]));
  assign wsat      = mnbm_pkg::sat16(wsum);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mnbm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (in_data.mode)
            mnbm_pkg::MODE_LOAD:     state_next = mnbm_pkg::ST_LOAD;
            mnbm_pkg::MODE_FORWARD:  state_next = mnbm_pkg::ST_FMUL;
            mnbm_pkg::MODE_OUT_GRAD: state_next = mnbm_pkg::ST_SQ;
            mnbm_pkg::MODE_HID_GRAD: state_next = mnbm_pkg::ST_HMUL;
            mnbm_pkg::MODE_UPDATE:
              state_next = in_ok ? mnbm_pkg::ST_UMUL1 : mnbm_pkg::ST_IDLE;
            default:                 state_next = mnbm_pkg::ST_IDLE;
          endcase
        end
      end
      mnbm_pkg::ST_LOAD:  state_next = mnbm_pkg::ST_IDLE;
      mnbm_pkg::ST_FMUL:  state_next = mnbm_pkg::ST_ACC;
      mnbm_pkg::ST_HMUL:  state_next = mnbm_pkg::ST_ACC;
      mnbm_pkg::ST_ACC: begin
        if (!cur.last_term) begin
          state_next = mnbm_pkg::ST_IDLE;
        end else if (cur.mode == mnbm_pkg::MODE_FORWARD) begin
          state_next = mnbm_pkg::ST_TIDX;
        end else begin
          state_next = mnbm_pkg::ST_SQ;
        end
      end
      mnbm_pkg::ST_TIDX:  state_next = mnbm_pkg::ST_TOUT;
      mnbm_pkg::ST_SQ:    state_next = mnbm_pkg::ST_DER;
      mnbm_pkg::ST_DER: begin
        state_next = (cur.mode == mnbm_pkg::MODE_OUT_GRAD) ?
                     mnbm_pkg::ST_GMUL : mnbm_pkg::ST_HLO;
      end
      mnbm_pkg::ST_GMUL:  state_next = mnbm_pkg::ST_GOUT;
      mnbm_pkg::ST_HLO:   state_next = mnbm_pkg::ST_HHI;
      mnbm_pkg::ST_HHI:   state_next = mnbm_pkg::ST_HSUM;
      mnbm_pkg::ST_HSUM:  state_next = mnbm_pkg::ST_HOUT;
      mnbm_pkg::ST_UMUL1: state_next = mnbm_pkg::ST_UMUL2;
      mnbm_pkg::ST_UMUL2: state_next = mnbm_pkg::ST_UMUL3;
      mnbm_pkg::ST_UMUL3: state_next = mnbm_pkg::ST_USUM;
      mnbm_pkg::ST_USUM:  state_next = mnbm_pkg::ST_UOUT;
      mnbm_pkg::ST_TOUT, mnbm_pkg::ST_GOUT, mnbm_pkg::ST_HOUT, mnbm_pkg::ST_UOUT: begin
        if (out_free) begin
          state_next = mnbm_pkg::ST_IDLE;
        end
      end
      default: state_next = mnbm_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operands and result emission per step
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    emit      = 1'b0;
    emit_data = '0;
    case (state)
      mnbm_pkg::ST_FMUL: begin
        mul_a = cur_ok ? 30'(w_rd) : 30'sd0;
        mul_b = 17'(cur.operand_value);
      end
      mnbm_pkg::ST_HMUL: begin
        mul_a = 30'(cur.operand_value);
        mul_b = 17'(cur.partner_weight);
      end
      mnbm_pkg::ST_SQ: begin
        mul_a = 30'(nout);
        mul_b = 17'(nout);
      end
      mnbm_pkg::ST_GMUL: begin
        mul_a = 30'(gdiff);
        mul_b = 17'(dreg);
      end
      mnbm_pkg::ST_HLO: begin
        mul_a = $signed(30'(acc[mnbm_pkg::ACC_HALF-1:0]));
        mul_b = 17'(dreg);
      end
      mnbm_pkg::ST_HHI: begin
        mul_a = 30'($signed(acc[mnbm_pkg::ACC_W-1:mnbm_pkg::ACC_HALF]));
        mul_b = 17'(dreg);
      end
      mnbm_pkg::ST_UMUL1: begin
        mul_a = 30'(cur.operand_value);
        mul_b = $signed(17'(eta));
      end
      mnbm_pkg::ST_UMUL2: begin
        mul_a = prod[29:0];
        mul_b = 17'(ngrad);
      end
      mnbm_pkg::ST_UMUL3: begin
        mul_a = 30'(old_delta);
        mul_b = $signed(17'(alpha));
      end
      mnbm_pkg::ST_TOUT: begin
        emit      = out_free;
        emit_data = '{result_value: tout_val, result_kind: mnbm_pkg::KIND_ACT,
                      saturated: 1'b0};
      end
      mnbm_pkg::ST_GOUT: begin
        emit      = out_free;
        emit_data = '{result_value: g_sat[15:0], result_kind: mnbm_pkg::KIND_GRAD,
                      saturated: g_sat[16]};
      end
      mnbm_pkg::ST_HOUT: begin
        emit      = out_free;
        emit_data = '{result_value: h_sat[15:0], result_kind: mnbm_pkg::KIND_GRAD,
                      saturated: h_sat[16]};
      end
      mnbm_pkg::ST_UOUT: begin
        emit      = out_free;
        emit_data = '{result_value: wsat[15:0], result_kind: mnbm_pkg::KIND_WEIGHT,
                      saturated: dsat[16] | wsat[16]};
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Control state and neuron registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mnbm_pkg::ST_IDLE;
      acc       <= '0;
      nout      <= '0;
      ngrad     <= '0;
      eta       <= 12'd205;
      alpha     <= 12'd2048;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          mnbm_pkg::REG_LEARNING_RATE: eta   <= cfg_data;
          mnbm_pkg::REG_MOMENTUM:      alpha <= cfg_data;
          default:                     eta   <= eta;
        endcase
      end
      if (state == mnbm_pkg::ST_ACC) begin
        acc <= acc_next;
      end else if (emit && (state == mnbm_pkg::ST_TOUT || state == mnbm_pkg::ST_HOUT)) begin
        acc <= '0;
      end
      if (emit && state == mnbm_pkg::ST_TOUT) begin
        nout <= tout_val;
      end
      if (emit && (state == mnbm_pkg::ST_GOUT || state == mnbm_pkg::ST_HOUT)) begin
        ngrad <= emit_data.result_value;
      end
      // Hold the output until its transfer
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (emit) begin
      out_data <= emit_data;
    end
    if (in_xfer) begin
      cur    <= in_data;
      cur_ok <= in_ok;
    end
    if (state == mnbm_pkg::ST_TIDX) begin
      if (acc < mnbm_pkg::ACC_NLIM) begin
        tcls <= mnbm_pkg::TC_NEG;
      end else if (acc >= mnbm_pkg::ACC_LIM) begin
        tcls <= mnbm_pkg::TC_POS;
      end else begin
        tcls <= mnbm_pkg::TC_MID;
      end
    end
    if (state == mnbm_pkg::ST_DER) begin
      dreg <= dreg_next;
    end
    if (state == mnbm_pkg::ST_HHI) begin
      plo <= prod;
    end
    if (state == mnbm_pkg::ST_HSUM) begin
      gsum <= h_total[2*F +: 32];
    end
    if (state == mnbm_pkg::ST_UMUL3) begin
      areg <= prod;
    end
    if (state == mnbm_pkg::ST_USUM) begin
      nd <= u_sum[12+F +: 32];
    end
  end

  // Weight and delta memories: read at the input transfer, write at the end
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      w_rd <= weight_mem[in_addr];
      d_rd <= delta_mem[in_addr];
    end
    if (state == mnbm_pkg::ST_LOAD && cur_ok) begin
      weight_mem[cur_addr] <= cur.operand_value;
      delta_mem[cur_addr]  <= 16'sd0;
    end else if (emit && state == mnbm_pkg::ST_UOUT) begin
      weight_mem[cur_addr] <= wsat[15:0];
      delta_mem[cur_addr]  <= dsat[15:0];
    end
  end

  // Delta valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      dvalid <= '0;
      dv_rd  <= 1'b0;
    end else begin
      if (in_xfer) begin
        dv_rd <= dvalid[in_addr];
      end
      if ((state == mnbm_pkg::ST_LOAD && cur_ok) ||
          (emit && state == mnbm_pkg::ST_UOUT)) begin
        dvalid[cur_addr] <= 1'b1;
      end
    end
  end

endmodule
